// ===== src/tcw_pkg.sv =====
// ============================================================================
// Text console package
// Shared constants, command codes and types of the text console writer.
// ============================================================================
package tcw_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned CELL_W  = COLOR_W + CHAR_W;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned COL_W   = 7;

  localparam int unsigned CELLS   = ROWS * COLUMNS;
  localparam int unsigned ADDR_W  = $clog2(CELLS);
  localparam int unsigned FILL_W  = $clog2(COLUMNS + 1);

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;
  localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_NEWLINE,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } bk_state_e;

endpackage

// ===== src/tcw_front.sv =====
// ============================================================================
// Text console front end
// Accepts console words and turns them into executor commands.
// ============================================================================
module tcw_front
  import tcw_pkg::*;
(
  input  logic              start_i,
  input  logic              full_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [ROW_W-1:0]  read_row_i,
  input  logic [COL_W-1:0]  read_col_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  logic in_range;

  assign push_o   = start_i && !full_i;
  assign in_range = ({1'b0, read_row_i} < (ROW_W + 1)'(ROWS)) &&
                    ({1'b0, read_col_i} < (COL_W + 1)'(COLUMNS));

  always_comb begin
    cmd_o.ch  = char_code_i;
    cmd_o.row = read_row_i;
    cmd_o.col = read_col_i;
    case (kind_i)
      KIND_PUT: begin
        cmd_o.op = (char_code_i == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
      end
      KIND_READ: begin
        // A read outside the screen returns zero, like an unused kind.
        cmd_o.op = in_range ? OP_READ : OP_NOP;
      end
      KIND_CLEAR: begin
        cmd_o.op = OP_CLEAR;
      end
      default: begin
        cmd_o.op = OP_NOP;
      end
    endcase
  end

endmodule

// ===== src/tcw_queue.sv =====
// ============================================================================
// Text console command queue
// Small first-in first-out queue between the front end and the executor.
// ============================================================================
module tcw_queue
  import tcw_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output cmd_t cmd_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             data_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign cmd_o   = data_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== src/tcw_back.sv =====
// ============================================================================
// Text console executor
// Carries out queued commands on the screen store and produces the results.
// ============================================================================
module tcw_back
  import tcw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  cmd_t               q_cmd_i,
  output logic               q_pop_o,
  input  logic               cfg_valid_i,
  input  logic [COLOR_W-1:0] cfg_color_i,
  output logic               strobe_o,
  output logic [CELL_W-1:0]  cell_data_o,
  output logic [ROW_W-1:0]   cursor_row_o,
  output logic [COL_W-1:0]   cursor_col_o,
  output logic               scrolled_o
);

  // Each screen row keeps a fill count: columns below it were written since
  // the row was last blanked, the rest read as blanks in the row's colour.
  logic [CELL_W-1:0]  mem [CELLS];
  logic [FILL_W-1:0]  fill_q  [ROWS];
  logic [COLOR_W-1:0] bcol_q  [ROWS];

  bk_state_e          state_q, state_d;
  logic [COLOR_W-1:0] color_q;
  logic [ROW_W-1:0]   top_q, top_d;
  logic [ROW_W-1:0]   crow_q, crow_d;
  logic [COL_W-1:0]   ccol_q, ccol_d;
  logic [CELL_W-1:0]  rd_data_q;
  logic               hit_q, hit_d;
  logic [COLOR_W-1:0] blank_col_q, blank_col_d;
  logic               strobe_q, strobe_d;
  logic [CELL_W-1:0]  cell_q, cell_d;
  logic               scr_q, scr_d;

  logic [ROW_W-1:0]   cur_prow, rd_prow;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic               mem_we, mem_re, fill_we, blank_row_we, clear_all;

  function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W:0] s);
    logic [ROW_W:0] r;
    r = (s >= (ROW_W + 1)'(ROWS)) ? s - (ROW_W + 1)'(ROWS) : s;
    return r[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  assign cur_prow = wrap_row({1'b0, top_q} + {1'b0, crow_q});
  assign rd_prow  = wrap_row({1'b0, top_q} + {1'b0, q_cmd_i.row});
  assign waddr    = cell_addr(cur_prow, ccol_q);
  assign raddr    = cell_addr(rd_prow, q_cmd_i.col);

  always_comb begin
    state_d      = state_q;
    q_pop_o      = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    fill_we      = 1'b0;
    blank_row_we = 1'b0;
    clear_all    = 1'b0;
    top_d        = top_q;
    crow_d       = crow_q;
    ccol_d       = ccol_q;
    hit_d        = hit_q;
    blank_col_d  = blank_col_q;
    strobe_d     = 1'b0;
    cell_d       = '0;
    scr_d        = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            OP_PUT, OP_NEWLINE: begin
              strobe_d = 1'b1;
              if (q_cmd_i.op == OP_PUT) begin
                mem_we  = 1'b1;
                fill_we = 1'b1;
              end
              if (q_cmd_i.op == OP_PUT && ccol_q != COL_W'(COLUMNS - 1)) begin
                ccol_d = ccol_q + 1'b1;
              end else begin
                ccol_d = '0;
                if (crow_q == ROW_W'(ROWS - 1)) begin
                  // The old top row becomes the new bottom row.
                  top_d        = wrap_row({1'b0, top_q} + 1'b1);
                  blank_row_we = 1'b1;
                  scr_d        = 1'b1;
                end else begin
                  crow_d = crow_q + 1'b1;
                end
              end
            end
            OP_READ: begin
              mem_re      = 1'b1;
              hit_d       = FILL_W'(q_cmd_i.col) < fill_q[rd_prow];
              blank_col_d = bcol_q[rd_prow];
              state_d     = BK_READ;
            end
            OP_CLEAR: begin
              clear_all = 1'b1;
              top_d     = '0;
              crow_d    = '0;
              ccol_d    = '0;
              strobe_d  = 1'b1;
            end
            default: begin
              strobe_d = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        strobe_d = 1'b1;
        cell_d   = hit_q ? rd_data_q : {blank_col_q, BLANK_CHAR};
        state_d  = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      color_q  <= RESET_COLOR;
      top_q    <= '0;
      crow_q   <= '0;
      ccol_q   <= '0;
      strobe_q <= 1'b0;
      scr_q    <= 1'b0;
      cell_q   <= '0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      crow_q   <= crow_d;
      ccol_q   <= ccol_d;
      strobe_q <= strobe_d;
      scr_q    <= scr_d;
      cell_q   <= cell_d;
      if (cfg_valid_i) begin
        color_q <= cfg_color_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        fill_q[r] <= '0;
        bcol_q[r] <= RESET_COLOR;
      end
    end else begin
      for (int r = 0; r < ROWS; r++) begin
        if (clear_all) begin
          fill_q[r] <= '0;
          bcol_q[r] <= color_q;
        end else begin
          if (fill_we && cur_prow == ROW_W'(r)) begin
            fill_q[r] <= FILL_W'(ccol_q) + 1'b1;
          end
          if (blank_row_we && top_q == ROW_W'(r)) begin
            fill_q[r] <= '0;
            bcol_q[r] <= color_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q       <= hit_d;
    blank_col_q <= blank_col_d;
    if (mem_we) begin
      mem[waddr] <= {color_q, q_cmd_i.ch};
    end
    if (mem_re) begin
      rd_data_q <= mem[raddr];
    end
  end

  assign strobe_o     = strobe_q;
  assign cell_data_o  = cell_q;
  assign cursor_row_o = crow_q;
  assign cursor_col_o = ccol_q;
  assign scrolled_o   = scr_q;

endmodule

// ===== src/text_console_cell_writer.sv =====
// ============================================================================
// Text console cell writer
// Character console over a ring of screen rows with cursor, scroll and read.
// ============================================================================
//  Channel   Handshake                     Word
//  command   start_i, busy_o               kind_i, char_code_i, read_row_i, read_col_i
//  result    result_strobe_o (one cycle)   cell_data_o, cursor_row_out_o,
//                                          cursor_col_out_o, scrolled_o
//  config    cfg_valid_i, cfg_ready_o      cfg_text_color_i
//
// The executor takes one command per cycle while no read is in progress; a read
// also passes the BK_READ state, set by the registered read port of the screen
// memory. A result passes the command queue and the executor's result registers.
// Scroll and clear write no screen cells: per-row fill counts mark blank cells,
// so reset needs no clearing pass. busy_o is high while the command queue is full.
// ============================================================================
module text_console_cell_writer
  import tcw_pkg::*;
#(
  parameter int unsigned Q_DEPTH = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [ROW_W-1:0]   read_row_i,
  input  logic [COL_W-1:0]   read_col_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [COLOR_W-1:0] cfg_text_color_i,
  output logic               result_strobe_o,
  output logic [CELL_W-1:0]  cell_data_o,
  output logic [ROW_W-1:0]   cursor_row_out_o,
  output logic [COL_W-1:0]   cursor_col_out_o,
  output logic               scrolled_o
);

  logic push, q_valid, q_full, q_pop;
  cmd_t push_cmd, q_cmd;

  assign busy_o      = q_full;
  assign cfg_ready_o = 1'b1;

  tcw_front u_front (
    .start_i     (start_i),
    .full_i      (q_full),
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  tcw_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .cmd_o   (q_cmd)
  );

  tcw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .q_pop_o      (q_pop),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_color_i  (cfg_text_color_i),
    .strobe_o     (result_strobe_o),
    .cell_data_o  (cell_data_o),
    .cursor_row_o (cursor_row_out_o),
    .cursor_col_o (cursor_col_out_o),
    .scrolled_o   (scrolled_o)
  );

`ifndef SYNTHESIS
  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cursor_row_out_o} < (ROW_W + 1)'(ROWS)) &&
    ({1'b0, cursor_col_out_o} < (COL_W + 1)'(COLUMNS)))
    else $error("Cursor outside the screen.");

  a_scroll_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scrolled_o |-> result_strobe_o && cursor_row_out_o == ROW_W'(ROWS - 1) &&
                   cursor_col_out_o == '0)
    else $error("Scroll result without cursor at start of bottom row.");

  a_cell_on_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_data_o != '0) |-> result_strobe_o)
    else $error("Cell data driven outside a result word.");
`endif

endmodule

// ===== test/text_console_cell_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Text console cell checker
// Watches the command, configuration and result channels of the console
// writer, keeps its own copy of the screen ring, cursor and colour, and
// compares each result word field by field with the oldest prediction.
// ============================================================================
module text_console_cell_checker
  import tcw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [ROW_W-1:0]   read_row_i,
  input  logic [COL_W-1:0]   read_col_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [COLOR_W-1:0] cfg_text_color_i,
  input  logic               result_strobe_i,
  input  logic [CELL_W-1:0]  cell_data_i,
  input  logic [ROW_W-1:0]   cursor_row_i,
  input  logic [COL_W-1:0]   cursor_col_i,
  input  logic               scrolled_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [ROW_W-1:0]  row_pos;
    logic [COL_W-1:0]  col_pos;
    logic              scrolled;
  } console_echo_t;

  logic [CELL_W-1:0]  screen_model [CELLS];
  int unsigned        cur_row;
  int unsigned        cur_col;
  int unsigned        top_offset;
  logic [COLOR_W-1:0] color_model;
  console_echo_t      echo_queue [$];
  int unsigned        fails = 0;

  assign pending_o    = echo_queue.size();
  assign fail_count_o = fails;

  function automatic int unsigned ring_row(input int unsigned visible);
    return (top_offset + visible) % ROWS;
  endfunction

  function automatic void blank_row(input int unsigned prow);
    for (int unsigned c = 0; c < COLUMNS; c++) begin
      screen_model[prow * COLUMNS + c] = {color_model, BLANK_CHAR};
    end
  endfunction

  function automatic void clear_screen();
    top_offset = 0;
    for (int unsigned r = 0; r < ROWS; r++) begin
      blank_row(r);
    end
    cur_row = 0;
    cur_col = 0;
  endfunction

  function automatic console_echo_t predict_console(input logic [KIND_W-1:0] kind,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic [ROW_W-1:0]  row,
                                                    input logic [COL_W-1:0]  col);
    console_echo_t echo;
    echo = '0;
    case (kind)
      KIND_PUT: begin
        if (ch == NEWLINE_CHAR) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen_model[ring_row(cur_row) * COLUMNS + cur_col] = {color_model, ch};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= ROWS) begin
          top_offset = (top_offset + 1) % ROWS;
          blank_row(ring_row(ROWS - 1));
          cur_row = ROWS - 1;
          echo.scrolled = 1'b1;
        end
      end
      KIND_READ: begin
        if (row < ROWS && col < COLUMNS) begin
          echo.cell_data = screen_model[ring_row(row) * COLUMNS + col];
        end
      end
      KIND_CLEAR: begin
        clear_screen();
      end
      default: begin
      end
    endcase
    echo.row_pos = cur_row[ROW_W-1:0];
    echo.col_pos = cur_col[COL_W-1:0];
    return echo;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    console_echo_t want;
    if (!rst_ni) begin
      color_model = RESET_COLOR;
      clear_screen();
      echo_queue.delete();
    end else begin
      if (result_strobe_i) begin
        if (echo_queue.size() == 0) begin
          $error("result word with no command outstanding");
          fails++;
        end else begin
          want = echo_queue.pop_front();
          if (cell_data_i !== want.cell_data) begin
            $error("cell_data expected %h actual %h", want.cell_data, cell_data_i);
            fails++;
          end
          if (cursor_row_i !== want.row_pos) begin
            $error("cursor_row_out expected %0d actual %0d", want.row_pos, cursor_row_i);
            fails++;
          end
          if (cursor_col_i !== want.col_pos) begin
            $error("cursor_col_out expected %0d actual %0d", want.col_pos, cursor_col_i);
            fails++;
          end
          if (scrolled_i !== want.scrolled) begin
            $error("scrolled expected %b actual %b", want.scrolled, scrolled_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        color_model = cfg_text_color_i;
      end
      if (start_i && !busy_i) begin
        echo_queue.push_back(predict_console(kind_i, char_code_i, read_row_i, read_col_i));
      end
    end
  end

endmodule

// ===== test/tb_text_console_cell_writer.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Text console cell writer testbench
// Drives directed and random put, read, clear and unused commands in phases
// with different text colours and newline densities, with random idle bursts,
// and leaves prediction and comparison to the checker beside the block.
// ============================================================================
module tb_text_console_cell_writer
  import tcw_pkg::*;
();

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_WORDS   = 125;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [KIND_W-1:0]  kind_i;
  logic [CHAR_W-1:0]  char_code_i;
  logic [ROW_W-1:0]   read_row_i;
  logic [COL_W-1:0]   read_col_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [COLOR_W-1:0] cfg_text_color_i;
  logic               result_strobe_o;
  logic [CELL_W-1:0]  cell_data_o;
  logic [ROW_W-1:0]   cursor_row_out_o;
  logic [COL_W-1:0]   cursor_col_out_o;
  logic               scrolled_o;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_count = 0;

  text_console_cell_writer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .kind_i           (kind_i),
    .char_code_i      (char_code_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_text_color_i (cfg_text_color_i),
    .result_strobe_o  (result_strobe_o),
    .cell_data_o      (cell_data_o),
    .cursor_row_out_o (cursor_row_out_o),
    .cursor_col_out_o (cursor_col_out_o),
    .scrolled_o       (scrolled_o)
  );

  text_console_cell_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .kind_i           (kind_i),
    .char_code_i      (char_code_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_text_color_i (cfg_text_color_i),
    .result_strobe_i  (result_strobe_o),
    .cell_data_i      (cell_data_o),
    .cursor_row_i     (cursor_row_out_o),
    .cursor_col_i     (cursor_col_out_o),
    .scrolled_i       (scrolled_o),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_console_cell_writer test failed");
      $finish;
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                           input bit allow_idle);
    int unsigned gap;
    @(negedge clk_i);
    if (allow_idle && $urandom_range(0, 99) == 0) begin
      start_i = 1'b0;
      do @(negedge clk_i); while (pending != 0);
    end else if (allow_idle && $urandom_range(0, 5) == 0) begin
      start_i = 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk_i);
    end
    start_i     = 1'b1;
    kind_i      = kind;
    char_code_i = ch;
    read_row_i  = row;
    read_col_i  = col;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic send_random_word(input int unsigned newline_odds, input bit allow_idle);
    int unsigned       pick;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    pick = $urandom_range(0, 999);
    ch   = CHAR_W'($urandom_range(0, 255));
    row  = ROW_W'($urandom_range(0, 31));
    col  = COL_W'($urandom_range(0, 127));
    if (pick < 3) begin
      kind = KIND_UNUSED;
    end else if (pick < 6) begin
      kind = KIND_CLEAR;
    end else if (pick < 360) begin
      kind = KIND_READ;
      if ($urandom_range(0, 6) != 0) begin
        row = ROW_W'($urandom_range(0, ROWS - 1));
        col = COL_W'($urandom_range(0, COLUMNS - 1));
      end
    end else begin
      kind = KIND_PUT;
      if ($urandom_range(1, newline_odds) == 1) begin
        ch = NEWLINE_CHAR;
      end
    end
    send_word(kind, ch, row, col, allow_idle);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic [COLOR_W-1:0] color;
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    kind_i           = KIND_PUT;
    char_code_i      = '0;
    read_row_i       = '0;
    read_col_i       = '0;
    cfg_valid_i      = 1'b0;
    cfg_text_color_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(KIND_READ,   8'h00, 5'd0,  7'd0,   1'b1);
    send_word(KIND_PUT,    8'h00, 5'd31, 7'd127, 1'b1);
    send_word(KIND_PUT,    8'hFF, 5'd0,  7'd0,   1'b1);
    send_word(KIND_PUT,    8'h41, 5'd0,  7'd0,   1'b1);
    send_word(KIND_READ,   8'hFF, 5'd0,  7'd1,   1'b1);
    send_word(KIND_READ,   8'h00, 5'd0,  7'd0,   1'b1);
    send_word(KIND_READ,   8'h00, 5'd24, 7'd79,  1'b1);
    send_word(KIND_READ,   8'h00, 5'd25, 7'd0,   1'b1);
    send_word(KIND_READ,   8'h00, 5'd0,  7'd80,  1'b1);
    send_word(KIND_READ,   8'hFF, 5'd31, 7'd127, 1'b1);
    send_word(KIND_UNUSED, 8'hFF, 5'd31, 7'd127, 1'b1);
    send_word(KIND_PUT,    NEWLINE_CHAR, 5'd0, 7'd0, 1'b1);
    send_word(KIND_PUT,    BLANK_CHAR, 5'd0, 7'd0, 1'b1);
    send_word(KIND_READ,   8'h00, 5'd1,  7'd0,   1'b1);
    send_word(KIND_CLEAR,  8'hFF, 5'd31, 7'd127, 1'b1);
    send_word(KIND_READ,   8'h00, 5'd1,  7'd0,   1'b1);
    send_word(KIND_PUT,    NEWLINE_CHAR, 5'd0, 7'd0, 1'b1);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        wait_drained();
        case (phase)
          1:       color = 8'h00;
          2:       color = 8'hFF;
          4:       color = 8'h5A;
          6:       color = 8'hA5;
          default: color = COLOR_W'($urandom_range(0, 255));
        endcase
        cfg_valid_i      = 1'b1;
        cfg_text_color_i = color;
        @(posedge clk_i);
        while (!cfg_ready_o) @(posedge clk_i);
        @(negedge clk_i);
        cfg_valid_i = 1'b0;
      end
      repeat (PHASE_WORDS) begin
        send_random_word((phase % 2 == 0) ? 4 : 100, phase != PHASES - 1);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("text_console_cell_writer test passed");
    end else begin
      $display("text_console_cell_writer test failed");
    end
    $finish;
  end

endmodule

// ===== text_console_cell_writer.f =====
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_cell_writer.sv
test/text_console_cell_checker.sv
test/tb_text_console_cell_writer.sv
